### design/pmq_pkg.sv
// ---------------------------------------------------------------------------
// pmq_pkg: shared types and constants of the precedence message queue
// Item formats, action and status codes, the decoded command passed from
// the front end to the back end, and the rank mapping of precedence codes.
// ---------------------------------------------------------------------------
package pmq_pkg;

	// Action codes of an input item
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_FINE   = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	// Precedence code that rejects an insert
	localparam logic signed [3:0] PREC_REJECT = -4'sd1;

	// Rank given to every code outside the ranked classes
	localparam logic [2:0] RANK_UNRANKED = 3'd5;

	// Input item
	typedef struct packed {
		logic [1:0]        action;
		logic signed [3:0] precedence;
		logic [15:0]       msg_tag;
	} pmq_req_t;

	// Result item
	typedef struct packed {
		logic        ok;
		logic [1:0]  status;
		logic [15:0] head_tag;
		logic [2:0]  head_class;
		logic [4:0]  entry_count;
		logic        is_empty;
	} pmq_rsp_t;

	// Decoded operation
	typedef enum logic [2:0] {
		OP_INSERT,
		OP_REJECT,
		OP_REMOVE,
		OP_CLEAR,
		OP_NOP
	} pmq_op_t;

	// Command handed from front end to back end
	typedef struct packed {
		pmq_op_t     op;
		logic [2:0]  code;
		logic [2:0]  rank;
		logic [15:0] tag;
	} pmq_cmd_t;

	// Ranked classes keep their code, all others rank lowest
	function automatic logic [2:0] rank_of(input logic [2:0] code);
		logic [2:0] r;
		if (code inside {[3'd1:3'd4]}) begin
			r = code;
		end else begin
			r = RANK_UNRANKED;
		end
		return r;
	endfunction

endpackage

### design/pmq_front.sv
// ---------------------------------------------------------------------------
// pmq_front: item classifier
// Decodes action and precedence of an input item into an operation, the
// stored class code and its rank.
// ---------------------------------------------------------------------------
module pmq_front import pmq_pkg::*; (
	input  pmq_req_t req,
	output pmq_cmd_t cmd
);

	// Negative codes other than the reject code are stored as unranked zero
	logic [2:0] code;
	assign code = req.precedence[3] ? 3'd0 : req.precedence[2:0];

	// Operation decode
	always_comb begin
		cmd.code = code;
		cmd.rank = rank_of(code);
		cmd.tag  = req.msg_tag;
		case (req.action)
			ACT_INSERT: begin
				cmd.op = (req.precedence == PREC_REJECT) ? OP_REJECT : OP_INSERT;
			end
			ACT_REMOVE: cmd.op = OP_REMOVE;
			ACT_CLEAR:  cmd.op = OP_CLEAR;
			default:    cmd.op = OP_NOP;
		endcase
	end

endmodule

### design/pmq_cmd_fifo.sv
// ---------------------------------------------------------------------------
// pmq_cmd_fifo: two-entry command queue
// Decouples the classifier from the queue store so that each side can
// stall on its own.
// ---------------------------------------------------------------------------
module pmq_cmd_fifo import pmq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pmq_cmd_t push_cmd,
	output logic     full,
	input  logic     pop,
	output logic     valid,
	output pmq_cmd_t head
);

	pmq_cmd_t   buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = buf_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_cmd;
		end
	end

endmodule

### design/pmq_back.sv
// ---------------------------------------------------------------------------
// pmq_back: ordered entry store and result register
// A row of cells, head at cell 0, shifted in parallel on insert and
// remove; each command gives one result into the output register.
// ---------------------------------------------------------------------------
module pmq_back import pmq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_WIDTH   = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  pmq_cmd_t cmd,
	output logic     cmd_pop,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output pmq_rsp_t rsp
);

	localparam int SW = (TAG_WIDTH < 16) ? TAG_WIDTH : 16;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	logic [SW-1:0] tag_q   [QUEUE_DEPTH];
	logic [2:0]    class_q [QUEUE_DEPTH];
	logic [CW-1:0] occ_q;
	logic [CW-1:0] occ_n;
	logic          rsp_valid_q;
	pmq_rsp_t      rsp_q;
	pmq_rsp_t      rsp_d;

	logic [QUEUE_DEPTH-1:0] le;
	logic full;
	logic empty;
	logic do_ins;
	logic do_rem;

	// Take a command when the result register is free or being emptied
	assign cmd_pop   = cmd_valid && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign full   = (occ_q == DEPTH_C);
	assign empty  = (occ_q == '0);
	assign do_ins = cmd_pop && (cmd.op == OP_INSERT) && !full;
	assign do_rem = cmd_pop && (cmd.op == OP_REMOVE) && !empty;

	// Held entries of equal or higher rank form a prefix of the row
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			le[i] = (CW'(i) < occ_q) && (rank_of(class_q[i]) <= cmd.rank);
		end
	end

	// Cell 0: keep, take the new entry, or take from cell 1
	always_ff @(posedge clk) begin
		if (do_ins && !le[0]) begin
			tag_q[0]   <= cmd.tag[SW-1:0];
			class_q[0] <= cmd.code;
		end else if (do_rem) begin
			tag_q[0]   <= tag_q[1];
			class_q[0] <= class_q[1];
		end
	end

	// Remaining cells
	for (genvar g = 1; g < QUEUE_DEPTH; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_ins && !le[g]) begin
				if (le[g-1]) begin
					tag_q[g]   <= cmd.tag[SW-1:0];
					class_q[g] <= cmd.code;
				end else begin
					tag_q[g]   <= tag_q[g-1];
					class_q[g] <= class_q[g-1];
				end
			end else if (do_rem && (g < QUEUE_DEPTH - 1)) begin
				tag_q[g]   <= tag_q[(g + 1) % QUEUE_DEPTH];
				class_q[g] <= class_q[(g + 1) % QUEUE_DEPTH];
			end
		end
	end

	// Next occupancy and result
	always_comb begin
		occ_n            = occ_q;
		rsp_d.ok         = 1'b0;
		rsp_d.status     = ST_FINE;
		rsp_d.head_tag   = '0;
		rsp_d.head_class = '0;
		case (cmd.op)
			OP_INSERT: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					occ_n    = occ_q + CW'(1);
					rsp_d.ok = 1'b1;
				end
			end
			OP_REJECT: rsp_d.status = ST_REJECT;
			OP_REMOVE: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					occ_n            = occ_q - CW'(1);
					rsp_d.ok         = 1'b1;
					rsp_d.head_tag   = 16'(tag_q[0]);
					rsp_d.head_class = class_q[0];
				end
			end
			OP_CLEAR: occ_n = '0;
			default:  occ_n = occ_q;
		endcase
		rsp_d.entry_count = 5'(occ_n);
		rsp_d.is_empty    = (occ_n == '0);
	end

	// Occupancy and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				occ_q       <= occ_n;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

### design/precedence_message_queue_core.sv
// ---------------------------------------------------------------------------
// precedence_message_queue_core: stable priority queue of tags, four ranked classes and one unranked
// Front end classifies items, a two-entry command queue decouples it from
// the back end, which keeps the ordered entries and registers each result.
// ---------------------------------------------------------------------------
// Path: an accepted item is written into the command queue, and its result register loads
//   when the back end takes it from the queue, which a stalled result holds off.
// Throughput: one item per cycle while neither side stalls; every command is done by
//   the parallel compare-and-shift row of cells, with no busy state.
// Reset: arst_n clears occupancy, queue pointers and result valid; entries
//   are not cleared and are only read below the occupancy.
module precedence_message_queue_core import pmq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_WIDTH   = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  pmq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output pmq_rsp_t rsp
);

	pmq_cmd_t front_cmd;
	pmq_cmd_t queue_head;
	logic     queue_full;
	logic     queue_valid;
	logic     queue_pop;
	logic     queue_push;

	assign req_stall  = queue_full;
	assign queue_push = req_valid && !queue_full;

	// Classifier
	pmq_front u_front (
		.req (req),
		.cmd (front_cmd)
	);

	// Command queue
	pmq_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (queue_push),
		.push_cmd (front_cmd),
		.full     (queue_full),
		.pop      (queue_pop),
		.valid    (queue_valid),
		.head     (queue_head)
	);

	// Entry store and result register
	pmq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_WIDTH   (TAG_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_valid),
		.cmd       (queue_head),
		.cmd_pop   (queue_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### design/pmq_checker.sv
// ---------------------------------------------------------------------------
// pmq_checker: port-level checks of the precedence message queue
// Watches the result channel of the top level; bound to it below.
// ---------------------------------------------------------------------------
module pmq_checker import pmq_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input pmq_rsp_t rsp
);

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// Success always reports fine status
	a_ok_fine: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.ok |-> rsp.status == ST_FINE)
		else $error("ok with a failure status");

	// Head fields are zero unless a remove returned an entry
	a_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> rsp.head_tag == 16'd0 && rsp.head_class == 3'd0)
		else $error("head fields set without a successful remove");

	// Empty remove leaves an empty queue; a set empty flag comes with a zero count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_EMPTY || rsp.is_empty) |->
			rsp.is_empty && rsp.entry_count == 5'd0)
		else $error("empty flag and count disagree");

endmodule

bind precedence_message_queue_core pmq_checker u_pmq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for precedence_message_queue_core
// A short table of directed items (reset state, every action, code extremes,
// rejected and unranked codes, a full queue) is followed by about 1500 random
// items in phases of sender and receiver idling. Every result is checked
// field by field, against a given result or a mirror of the ordered queue kept in the bench.
// ---------------------------------------------------------------------------
module tb;
	import pmq_pkg::*;

	localparam int         DEPTH      = 16;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int         RANDOM_ITEMS = 1500;
	localparam int         PHASES       = 4;

	// Directed row: one item, repeated with the tag stepped, optional typed result
	typedef struct {
		pmq_req_t item;
		int       reps;
		bit       typed;
		pmq_rsp_t want;
	} plan_row_t;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	pmq_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	pmq_rsp_t rsp;

	// Mirror of the queue contents, head at index 0
	logic [15:0] mirror_tags [DEPTH];
	logic [2:0]  mirror_codes[DEPTH];
	int          mirror_count;

	pmq_rsp_t  due_results[$];
	plan_row_t plan[$];
	int        fail_count;
	int        send_idle_pct;
	int        stall_pct;
	int        hold_off;

	precedence_message_queue_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Clock, 4 ns period
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("[precedence_message_queue_core] ERROR");
		$finish;
	end

	// Ranked classes keep their code, everything else sorts last
	function automatic int class_rank(logic [2:0] code);
		return (code >= 3'd1 && code <= 3'd4) ? int'(code) : 5;
	endfunction

	// Apply one item to the mirror and return the result it should give
	function automatic pmq_rsp_t queue_step(pmq_req_t item);
		pmq_rsp_t   r;
		logic [2:0] code;
		int         slot;
		r    = '0;
		slot = 0;
		case (item.action)
			ACT_INSERT: begin
				if (item.precedence == PREC_REJECT) begin
					r.status = ST_REJECT;
				end else if (mirror_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// negative codes other than reject are held as code 0
					code = item.precedence[3] ? 3'd0 : item.precedence[2:0];
					for (int k = 0; k < mirror_count; k++) begin
						if (class_rank(mirror_codes[k]) <= class_rank(code))
							slot = k + 1;
					end
					for (int k = mirror_count; k > slot; k--) begin
						mirror_tags[k]  = mirror_tags[k-1];
						mirror_codes[k] = mirror_codes[k-1];
					end
					mirror_tags[slot]  = item.msg_tag;
					mirror_codes[slot] = code;
					mirror_count++;
					r.ok = 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (mirror_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.head_tag   = mirror_tags[0];
					r.head_class = mirror_codes[0];
					for (int k = 1; k < mirror_count; k++) begin
						mirror_tags[k-1]  = mirror_tags[k];
						mirror_codes[k-1] = mirror_codes[k];
					end
					mirror_count--;
					r.ok = 1'b1;
				end
			end
			ACT_CLEAR: begin
				mirror_count = 0;
			end
			default: ;
		endcase
		r.entry_count = mirror_count[4:0];
		r.is_empty    = (mirror_count == 0);
		return r;
	endfunction

	// Result with no head entry, as given by inserts, errors and clears
	function automatic pmq_rsp_t plain_rsp(logic ok, logic [1:0] st, int count);
		pmq_rsp_t r;
		r             = '0;
		r.ok          = ok;
		r.status      = st;
		r.entry_count = count[4:0];
		r.is_empty    = (count == 0);
		return r;
	endfunction

	task automatic add_row(logic [1:0] act, int prec, logic [15:0] tag, int reps,
			bit typed, pmq_rsp_t want);
		plan_row_t row;
		row.item.action     = act;
		row.item.precedence = prec[3:0];
		row.item.msg_tag    = tag;
		row.reps            = reps;
		row.typed           = typed;
		row.want            = want;
		plan.push_back(row);
	endtask

	// Random item; insert_pct steers the fill level of the queue
	function automatic pmq_req_t random_item(int insert_pct);
		pmq_req_t it;
		int       roll;
		int       pick;
		roll       = $urandom_range(99);
		pick       = $urandom_range(99);
		it.msg_tag = 16'($urandom);
		if (roll < insert_pct)
			it.action = ACT_INSERT;
		else if (roll < 96)
			it.action = ACT_REMOVE;
		else if (roll < 98)
			it.action = ACT_CLEAR;
		else
			it.action = ACT_UNUSED;
		if (pick < 5)
			it.precedence = PREC_REJECT;
		else if (pick < 75)
			it.precedence = 4'($urandom_range(4, 1));
		else
			it.precedence = 4'($urandom);
		return it;
	endfunction

	// Offer one item from a falling edge, wait for acceptance, log its result
	task automatic offer(pmq_req_t item, bit typed, pmq_rsp_t want);
		pmq_rsp_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted = queue_step(item);
		due_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Sender pause until every logged result has arrived
	task automatic drain;
		req_valid <= 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic report_field(string fld, longint unsigned want, longint unsigned got);
		fail_count++;
		$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fld, want, got);
	endtask

	// Receiver: random stall, or a counted hold-off when one is requested
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				rsp_stall <= 1'b1;
				hold_off--;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		pmq_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_results.size() == 0) begin
				fail_count++;
				$display("%0t: result 0x%0h arrived with none outstanding", $time, rsp);
			end else begin
				want = due_results.pop_front();
				if (rsp.ok !== want.ok)
					report_field("ok", want.ok, rsp.ok);
				if (rsp.status !== want.status)
					report_field("status", want.status, rsp.status);
				if (rsp.head_tag !== want.head_tag)
					report_field("head_tag", want.head_tag, rsp.head_tag);
				if (rsp.head_class !== want.head_class)
					report_field("head_class", want.head_class, rsp.head_class);
				if (rsp.entry_count !== want.entry_count)
					report_field("entry_count", want.entry_count, rsp.entry_count);
				if (rsp.is_empty !== want.is_empty)
					report_field("is_empty", want.is_empty, rsp.is_empty);
			end
		end
	end

	// Stimulus
	initial begin
		pmq_req_t  item;
		plan_row_t row;
		int        insert_pct;
		int        per_phase;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		fail_count    = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_off      = 0;
		mirror_count  = 0;
		insert_pct    = 50;
		per_phase     = RANDOM_ITEMS / PHASES;

		// Directed table: reset state, every action, code extremes, full queue
		add_row(ACT_REMOVE, 0, 16'h0000, 1, 1, plain_rsp(1'b0, ST_EMPTY, 0));
		add_row(ACT_UNUSED, 3, 16'hFFFF, 1, 1, plain_rsp(1'b0, ST_FINE, 0));
		add_row(ACT_INSERT, -1, 16'hFFFF, 1, 1, plain_rsp(1'b0, ST_REJECT, 0));
		add_row(ACT_INSERT, 4, 16'hFFFF, 1, 1, plain_rsp(1'b1, ST_FINE, 1));
		add_row(ACT_INSERT, 1, 16'h0000, 1, 1, plain_rsp(1'b1, ST_FINE, 2));
		add_row(ACT_INSERT, 0, 16'h1234, 1, 0, '0);
		add_row(ACT_INSERT, 7, 16'hABCD, 1, 0, '0);
		add_row(ACT_INSERT, -8, 16'h8000, 1, 0, '0);
		add_row(ACT_INSERT, -2, 16'h0001, 1, 0, '0);
		add_row(ACT_INSERT, 2, 16'h5555, 1, 0, '0);
		add_row(ACT_INSERT, 1, 16'hAAAA, 1, 0, '0);
		add_row(ACT_REMOVE, 0, 16'h0000, 3, 0, '0);
		add_row(ACT_CLEAR, 5, 16'hFFFF, 1, 1, plain_rsp(1'b0, ST_FINE, 0));
		add_row(ACT_INSERT, 3, 16'h4000, DEPTH, 0, '0);
		add_row(ACT_INSERT, 1, 16'hFFFF, 1, 1, plain_rsp(1'b0, ST_FULL, DEPTH));
		add_row(ACT_INSERT, -1, 16'h0000, 1, 1, plain_rsp(1'b0, ST_REJECT, DEPTH));
		add_row(ACT_UNUSED, 0, 16'h0000, 1, 1, plain_rsp(1'b0, ST_FINE, DEPTH));
		add_row(ACT_REMOVE, -1, 16'hFFFF, 2, 0, '0);
		add_row(ACT_CLEAR, 0, 16'h0000, 1, 1, plain_rsp(1'b0, ST_FINE, 0));
		add_row(ACT_REMOVE, 7, 16'hFFFF, 1, 1, plain_rsp(1'b0, ST_EMPTY, 0));

		// Hold reset, then release it on a falling edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			for (int n = 0; n < row.reps; n++) begin
				item         = row.item;
				item.msg_tag = row.item.msg_tag + 16'(n);
				offer(item, row.typed, row.want);
			end
		end
		drain();

		// Random phases: none, sender idle, receiver stalls, both
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 54; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 54; end
				default: begin send_idle_pct = 24; stall_pct = 24; end
			endcase
			// long receiver hold-off while items keep coming, to back up the input
			if (ph == 0)
				hold_off = 80;
			for (int n = 0; n < per_phase; n++) begin
				if (n % 25 == 0) begin
					case ($urandom_range(3))
						0: insert_pct = 20;
						1: insert_pct = 45;
						2: insert_pct = 55;
						default: insert_pct = 85;
					endcase
				end
				// an unbroken stretch inside each phase
				if (n == per_phase / 2)
					begin send_idle_pct = 0; stall_pct = 0; end
				offer(random_item(insert_pct), 1'b0, '0);
			end
			drain();
		end

		// All accepted: wait out the pipeline, then report
		req_valid <= 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("[precedence_message_queue_core] OK");
		end else begin
			$display("[precedence_message_queue_core] ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
design/pmq_pkg.sv
design/pmq_front.sv
design/pmq_cmd_fifo.sv
design/pmq_back.sv
design/precedence_message_queue_core.sv
design/pmq_checker.sv
dv/tb.sv
